[rtl/spdg_pkg.sv]
// shared constants, field widths and control types for the shortest path block
// no dependencies; compiled first
`default_nettype none

package spdg_pkg;

  // default sizes handed to the top level parameters
  localparam int NODES_DEF       = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  // fixed widths of the stream fields
  localparam int NODE_FIELD_BITS   = 4;
  localparam int WEIGHT_FIELD_BITS = 16;
  localparam int DIST_BITS         = 20;
  localparam int S_DATA_BITS       = 32;
  localparam int M_DATA_BITS       = 32;

  // path sums saturate here
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  // at most this many results per run
  localparam int OUT_CAP = 16;

  // item kinds carried on s_tuser
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load_wr;
    logic run_start;
    logic relax_step;
    logic settle;
    logic out_read;
    logic out_load;
  } spdg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic load_req;
    logic run_req;
    logic t_last;
    logic out_last;
    logic found;
    logic out_free;
  } spdg_status_t;

endpackage

`default_nettype wire

[rtl/spdg_datapath.sv]
// datapath: weight matrix memory, distance and parent memories, relax unit,
// running minimum and result register; depends on spdg_pkg
`default_nettype none

module spdg_datapath #(
  parameter int NODES       = spdg_pkg::NODES_DEF,
  parameter int WEIGHT_BITS = spdg_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire spdg_pkg::spdg_cmd_t                     cmd,
  output spdg_pkg::spdg_status_t                       status,
  input  wire logic                                    kind,
  input  wire logic [spdg_pkg::NODE_FIELD_BITS-1:0]    from_node,
  input  wire logic [spdg_pkg::NODE_FIELD_BITS-1:0]    to_node,
  input  wire logic [spdg_pkg::WEIGHT_FIELD_BITS-1:0]  weight,
  input  wire logic                                    edge_present,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic [spdg_pkg::NODE_FIELD_BITS-1:0]         out_node,
  output logic [spdg_pkg::DIST_BITS-1:0]               out_distance,
  output logic                                         out_reachable,
  output logic [spdg_pkg::NODE_FIELD_BITS-1:0]         out_parent,
  output logic                                         out_last
);

  import spdg_pkg::*;

  localparam int NODE_BITS  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int ADDR_BITS  = $clog2(NODES * NODES);
  localparam int EXT_BITS   = NODE_BITS + NODE_FIELD_BITS;
  localparam int ENTRY_BITS = WEIGHT_BITS + 1;
  localparam int SUM_BITS   = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;
  localparam int OUT_COUNT  = (NODES < OUT_CAP) ? NODES : OUT_CAP;

  // {present, weight} per edge, row = origin
  logic [ENTRY_BITS-1:0] weight_mem [NODES*NODES];
  logic [DIST_BITS-1:0]  dist_mem   [NODES];
  logic [NODE_BITS-1:0]  pred_mem   [NODES];

  logic [ADDR_BITS-1:0]  clr;
  logic [NODE_BITS-1:0]  t;
  logic [NODE_BITS-1:0]  t_d;
  logic                  proc_valid;
  logic [NODES-1:0]      reached;
  logic [NODES-1:0]      settled;
  logic [NODE_BITS-1:0]  here;
  logic [DIST_BITS-1:0]  here_dist;
  logic                  found;
  logic [NODE_BITS-1:0]  min_idx;
  logic [DIST_BITS-1:0]  min_dist;

  logic [ENTRY_BITS-1:0] w_q;
  logic [DIST_BITS-1:0]  dist_q;
  logic [NODE_BITS-1:0]  pred_q;
  logic                  reached_q;

  logic [EXT_BITS-1:0]   from_ext;
  logic [EXT_BITS-1:0]   to_ext;
  logic                  from_ok;
  logic                  to_ok;
  logic [NODE_BITS-1:0]  from_idx;
  logic [NODE_BITS-1:0]  to_idx;
  logic [NODES-1:0]      src_onehot;

  logic                  w_en;
  logic [ADDR_BITS-1:0]  w_addr;
  logic [ENTRY_BITS-1:0] w_data;
  logic [ADDR_BITS-1:0]  r_addr;

  logic [SUM_BITS-1:0]   sum;
  logic [DIST_BITS-1:0]  cost;
  logic                  was_reached;
  logic                  upd;
  logic [DIST_BITS-1:0]  new_dist;
  logic                  cand;
  logic                  better;

  // input decode
  assign from_ext = EXT_BITS'(from_node);
  assign to_ext   = EXT_BITS'(to_node);
  assign from_ok  = from_ext < EXT_BITS'(NODES);
  assign to_ok    = to_ext < EXT_BITS'(NODES);
  assign from_idx = from_ext[NODE_BITS-1:0];
  assign to_idx   = to_ext[NODE_BITS-1:0];
  assign src_onehot = {{(NODES-1){1'b0}}, 1'b1} << from_idx;

  assign status.load_req   = (kind == KIND_LOAD) && from_ok && to_ok;
  assign status.run_req    = (kind == KIND_RUN) && from_ok;
  assign status.clear_last = (clr == ADDR_BITS'(NODES * NODES - 1));
  assign status.t_last     = (t == NODE_BITS'(NODES - 1));
  assign status.out_last   = (t == NODE_BITS'(OUT_COUNT - 1));
  assign status.found      = found;
  assign status.out_free   = !out_valid || out_ready;

  // weight matrix port
  assign w_en   = cmd.clear_step || cmd.load_wr;
  assign w_addr = cmd.clear_step ? clr : ADDR_BITS'(from_idx * NODES + to_idx);
  assign w_data = cmd.clear_step ? '0 :
                  {edge_present, edge_present ? WEIGHT_BITS'(weight) : WEIGHT_BITS'(0)};
  assign r_addr = ADDR_BITS'(here * NODES + t);

  always_ff @(posedge clk) begin
    if (w_en) begin
      weight_mem[w_addr] <= w_data;
    end
    if (cmd.relax_step) begin
      w_q <= weight_mem[r_addr];
    end
  end

  // relax stage, one edge of the current row per cycle
  assign sum         = SUM_BITS'(here_dist) + SUM_BITS'(w_q[WEIGHT_BITS-1:0]);
  assign cost        = (sum > SUM_BITS'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
  assign was_reached = reached[t_d];
  assign upd         = proc_valid && (t_d != here) && w_q[ENTRY_BITS-1] &&
                       (!was_reached || (cost < dist_q));
  assign new_dist    = upd ? cost : dist_q;
  // next node to settle is tracked during the pass, lowest index wins ties
  assign cand        = proc_valid && (upd || was_reached) && !settled[t_d];
  assign better      = !found || (new_dist < min_dist);

  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      dist_mem[from_idx] <= '0;
      pred_mem[from_idx] <= from_idx;
    end else if (upd) begin
      dist_mem[t_d] <= cost;
      pred_mem[t_d] <= here;
    end
    if (cmd.relax_step || cmd.out_read) begin
      dist_q <= dist_mem[t];
      pred_q <= pred_mem[t];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr        <= '0;
      t          <= '0;
      proc_valid <= 1'b0;
      reached    <= '0;
      settled    <= '0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      proc_valid <= cmd.relax_step;
      if (cmd.clear_step) begin
        clr <= clr + ADDR_BITS'(1);
      end
      if (cmd.run_start) begin
        reached <= src_onehot;
        settled <= src_onehot;
        found   <= 1'b0;
        t       <= '0;
      end
      if (cmd.settle) begin
        settled[min_idx] <= 1'b1;
        found            <= 1'b0;
        t                <= '0;
      end
      if (cmd.relax_step) begin
        t <= status.t_last ? '0 : t + NODE_BITS'(1);
      end
      if (cmd.out_load) begin
        t <= status.out_last ? '0 : t + NODE_BITS'(1);
      end
      if (upd) begin
        reached[t_d] <= 1'b1;
      end
      if (cand && better) begin
        found <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      here      <= from_idx;
      here_dist <= '0;
    end
    if (cmd.settle) begin
      here      <= min_idx;
      here_dist <= min_dist;
    end
    if (cand && better) begin
      min_idx  <= t_d;
      min_dist <= new_dist;
    end
    if (cmd.relax_step) begin
      t_d <= t;
    end
    if (cmd.out_read) begin
      reached_q <= reached[t];
    end
    if (cmd.out_load) begin
      out_node      <= NODE_FIELD_BITS'(t);
      out_distance  <= reached_q ? dist_q : '0;
      out_reachable <= reached_q;
      out_parent    <= reached_q ? NODE_FIELD_BITS'(pred_q) : NODE_FIELD_BITS'(t);
      out_last      <= status.out_last;
    end
  end

  a_settled_reached: assert property (@(posedge clk) disable iff (rst)
    (settled & ~reached) == '0)
    else $error("settled node that was never reached");

  a_min_open: assert property (@(posedge clk) disable iff (rst)
    found |-> !settled[min_idx])
    else $error("minimum candidate already settled");

  a_settle_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.settle |=> $countones(settled) == $countones($past(settled)) + 1)
    else $error("settle did not add exactly one node");

  a_run_init: assert property (@(posedge clk) disable iff (rst)
    cmd.run_start |=> $onehot(settled) && (settled == reached) && !found)
    else $error("run did not start from the source alone");

endmodule

`default_nettype wire

[rtl/spdg_ctrl.sv]
// controller: sequences matrix clear, loads, relax rounds and result readout
// depends on spdg_pkg
`default_nettype none

module spdg_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  output spdg_pkg::spdg_cmd_t         cmd,
  input  wire spdg_pkg::spdg_status_t status
);

  import spdg_pkg::*;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_RELAX    = 3'd2;
  localparam logic [2:0] ST_DRAIN    = 3'd3;
  localparam logic [2:0] ST_PICK     = 3'd4;
  localparam logic [2:0] ST_OUT_RD   = 3'd5;
  localparam logic [2:0] ST_OUT_LOAD = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load_wr = status.load_req;
          if (status.run_req) begin
            cmd.run_start = 1'b1;
            state_next    = ST_RELAX;
          end
        end
      end
      ST_RELAX: begin
        cmd.relax_step = 1'b1;
        if (status.t_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        if (status.found) begin
          cmd.settle = 1'b1;
          state_next = ST_RELAX;
        end else begin
          state_next = ST_OUT_RD;
        end
      end
      ST_OUT_RD: begin
        cmd.out_read = 1'b1;
        state_next   = ST_OUT_LOAD;
      end
      ST_OUT_LOAD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = status.out_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[rtl/shortest_path_dense_graph.sv]
// top level: single-source shortest paths over a dense weight matrix
// depends on spdg_pkg, spdg_ctrl, spdg_datapath
//
// channel  dir  word contents (low bit up)
// -------  ---  -------------------------------------------------------------
// s_*      in   tdata: from_node[3:0] to_node[7:4] weight[23:8] edge_present[24]
//               tuser: kind (0 load edge, 1 run from source)
// m_*      out  tdata: node[3:0] distance[23:4] reachable[24] parent_node[28:25]
//               tlast: last result of a run
//
// after reset the matrix is cleared to all edges absent, one entry per cycle, with
//   s_tready low until the clear sweep is done
// load words are written as they are accepted, back to back; loads outside the matrix are dropped
// a run starts from the source, then for each settled node (the source first) a relax
//   pass reads one matrix entry per cycle and picks the next node to settle; then each
//   result is read out of the distance memory and loaded into the output register
// a run whose source is outside the graph returns no words
// m_tready low stalls the readout; the last result sits in the output register
//   while the next word is already accepted
`default_nettype none

module shortest_path_dense_graph #(
  parameter int NODES       = spdg_pkg::NODES_DEF,
  parameter int WEIGHT_BITS = spdg_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // from_node[3:0] to_node[7:4] weight[23:8] edge_present[24], zero above
  input  wire logic [spdg_pkg::S_DATA_BITS-1:0] s_tdata,
  // kind[0]
  input  wire logic [0:0]                       s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // node[3:0] distance[23:4] reachable[24] parent_node[28:25], zero above
  output logic [spdg_pkg::M_DATA_BITS-1:0]      m_tdata,
  output logic                                  m_tlast
);

  import spdg_pkg::*;

  spdg_cmd_t    cmd;
  spdg_status_t status;

  // unpacked input word
  logic                         kind;
  logic [NODE_FIELD_BITS-1:0]   from_node;
  logic [NODE_FIELD_BITS-1:0]   to_node;
  logic [WEIGHT_FIELD_BITS-1:0] weight;
  logic                         edge_present;

  // result register fields
  logic [NODE_FIELD_BITS-1:0]   node;
  logic [DIST_BITS-1:0]         distance;
  logic                         reachable;
  logic [NODE_FIELD_BITS-1:0]   parent_node;

  assign kind         = s_tuser[0];
  assign from_node    = s_tdata[3:0];
  assign to_node      = s_tdata[7:4];
  assign weight       = s_tdata[23:8];
  assign edge_present = s_tdata[24];

  // sequencer: clear sweep, load/run decode, relax rounds, readout
  spdg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // memories, relax arithmetic and running minimum
  spdg_datapath #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .kind          (kind),
    .from_node     (from_node),
    .to_node       (to_node),
    .weight        (weight),
    .edge_present  (edge_present),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_node      (node),
    .out_distance  (distance),
    .out_reachable (reachable),
    .out_parent    (parent_node),
    .out_last      (m_tlast)
  );

  // pack the result word, zero fill to the bus width
  assign m_tdata = {3'b000, parent_node, reachable, distance, node};

endmodule

`default_nettype wire
